>>> design/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants for the positional array list
// Store depth, field widths, command codes, FSM states and the control
// bundle that the top level hands to every list cell.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int DEPTH       = 64;
  localparam int IDX_W       = 6;   // bits to index DEPTH cells
  localparam int LEN_W       = 7;   // bits to hold 0..DEPTH and list positions
  localparam int VAL_W       = 32;
  localparam int CMD_W       = 2;
  localparam int CAP_RESET   = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_FIND   = 2'd3
  } plc_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_CELL   = 2'd1,
    S_REDUCE = 2'd2
  } plc_state_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic             ins;     // shift up from the insert slot, load value there
    logic             del;     // shift down from the delete slot
    logic             sample;  // capture match and select flags
    logic [LEN_W-1:0] p0;      // zero-based position
    logic [LEN_W-1:0] count;   // list length before the command
    logic [VAL_W-1:0] value;   // value to insert or to look for
  } plc_ctrl_t;

endpackage

>>> design/plc_ifs.sv
// ----------------------------------------------------------------------------
// plc_ifs: channel interfaces of the positional array list
// Command input, result output and capacity register write channel, each
// with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface plc_in_if import plc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [LEN_W-1:0]        position;
  logic signed [VAL_W-1:0] item_value;

  modport source (output valid, command, position, item_value, input ready);
  modport sink   (input valid, command, position, item_value, output ready);
endinterface

interface plc_out_if import plc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic signed [VAL_W-1:0] read_value;
  logic [LEN_W-1:0]        found_position;
  logic [LEN_W-1:0]        list_length;

  modport source (output valid, ok, read_value, found_position, list_length,
                  input ready);
  modport sink   (input valid, ok, read_value, found_position, list_length,
                  output ready);
endinterface

interface plc_cfg_if import plc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

>>> design/plc_cell.sv
// ----------------------------------------------------------------------------
// plc_cell: one slot of the list
// Holds one entry, takes its left or right neighbour's entry on insert and
// delete, and flags a match or a positional select for the reduction stage.
// ----------------------------------------------------------------------------
module plc_cell import plc_pkg::*; (
  input  logic             clk,
  input  plc_ctrl_t        ctrl,
  input  logic [IDX_W-1:0] idx,
  input  logic [VAL_W-1:0] left_value,
  input  logic [VAL_W-1:0] right_value,
  output logic [VAL_W-1:0] entry_r,
  output logic             hit_r,
  output logic [VAL_W-1:0] sel_r
);

  logic [LEN_W-1:0] idx_ext;
  logic [VAL_W-1:0] entry_nxt;
  logic             hit_nxt;
  logic [VAL_W-1:0] sel_nxt;

  assign idx_ext = LEN_W'(idx);

  // Pick the next entry: hold, take a neighbour, or load the new value
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (idx_ext == ctrl.p0) begin
        entry_nxt = ctrl.value;
      end else if (idx_ext > ctrl.p0 && idx_ext <= ctrl.count) begin
        entry_nxt = left_value;
      end
    end else if (ctrl.del) begin
      if (idx_ext >= ctrl.p0 && (idx_ext + LEN_W'(1)) < ctrl.count) begin
        entry_nxt = right_value;
      end
    end
  end

  // Flag a live matching entry and offer this entry when it is selected
  assign hit_nxt = (entry_r == ctrl.value) && (idx_ext < ctrl.count);
  assign sel_nxt = (idx_ext == ctrl.p0) ? entry_r : '0;

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctrl.sample) begin
      hit_r <= hit_nxt;
      sel_r <= sel_nxt;
    end
  end

endmodule

>>> design/plc_reduce.sv
// ----------------------------------------------------------------------------
// plc_reduce: fold of the cell flags
// Merges the selected entry of the row and finds the first matching cell.
// ----------------------------------------------------------------------------
module plc_reduce import plc_pkg::*; (
  input  logic [DEPTH-1:0]            hit,
  input  logic [DEPTH-1:0][VAL_W-1:0] sel,
  output logic                        any_hit,
  output logic [LEN_W-1:0]            first_pos,
  output logic [VAL_W-1:0]            sel_value
);

  // OR the select words: at most one cell offers a non-zero word
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_value = sel_value | sel[i];
    end
  end

  // Lowest matching cell wins; report it 1-based
  always_comb begin
    first_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        first_pos = LEN_W'(i + 1);
      end
    end
  end

  assign any_hit = |hit;

endmodule

>>> design/positional_array_list.sv
// ----------------------------------------------------------------------------
// positional_array_list: packed ordered list of signed 32-bit values
// Each command is captured, the cells update and sample their flags, and the
//   reduction loads the result register, waiting while a result is not taken;
//   only then is a new command accepted, also while a result waits.
// Reset: list empty, capacity limit 10, no result pending; entries undefined.
// ----------------------------------------------------------------------------
module positional_array_list import plc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  plc_in_if.sink    in_ch,
  plc_out_if.source out_ch,
  plc_cfg_if.sink   cfg_ch
);

  plc_state_t       state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r;
  logic [LEN_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] cap_r;
  logic             ok_r, ok_nxt;

  logic             out_valid_r;
  logic             out_ok_r;
  logic [VAL_W-1:0] out_rd_r;
  logic [LEN_W-1:0] out_fp_r;
  logic [LEN_W-1:0] out_len_r;

  logic             accept;
  logic             out_load;
  logic [LEN_W-1:0] eff_cap;
  logic             pos_ok;
  logic             ins_ok;
  plc_ctrl_t        ctrl;

  logic [DEPTH-1:0][VAL_W-1:0] entry;
  logic [DEPTH-1:0][VAL_W-1:0] sel;
  logic [DEPTH-1:0]            hit;
  logic                        any_hit;
  logic [LEN_W-1:0]            first_pos;
  logic [VAL_W-1:0]            sel_value;

  // Capacity register: ready whenever out of reset
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= LEN_W'(CAP_RESET);
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.capacity_limit;
    end
  end

  // Range checks against the current length
  assign eff_cap = (cap_r > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : cap_r;
  assign pos_ok  = (pos_r != '0) && (pos_r <= count_r);
  assign ins_ok  = (count_r < eff_cap) && (pos_r != '0) &&
                   ({1'b0, pos_r} <= ({1'b0, count_r} + (LEN_W + 1)'(1)));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_ch.valid) state_nxt = S_CELL;
      S_CELL:   state_nxt = S_REDUCE;
      S_REDUCE: if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    ctrl.ins    = 1'b0;
    ctrl.del    = 1'b0;
    ctrl.sample = 1'b0;
    ctrl.p0     = pos_r - LEN_W'(1);
    ctrl.count  = count_r;
    ctrl.value  = val_r;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = rst_n;
      end
      S_CELL: begin
        ctrl.ins    = (cmd_r == CMD_INSERT) && ins_ok;
        ctrl.del    = (cmd_r == CMD_DELETE) && pos_ok;
        ctrl.sample = 1'b1;
      end
      S_REDUCE: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  // Status and new length, settled in the cell step
  always_comb begin
    ok_nxt    = ok_r;
    count_nxt = count_r;
    if (state_r == S_CELL) begin
      case (cmd_r)
        CMD_INSERT: begin
          ok_nxt = ins_ok;
          if (ins_ok) count_nxt = count_r + LEN_W'(1);
        end
        CMD_DELETE: begin
          ok_nxt = pos_ok;
          if (pos_ok) count_nxt = count_r - LEN_W'(1);
        end
        default: ok_nxt = pos_ok;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Capture the command beat
  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
    if (accept) begin
      cmd_r <= in_ch.command;
      pos_r <= in_ch.position;
      val_r <= in_ch.item_value;
    end
  end

  // Row of list cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_value;
    logic [VAL_W-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_mid_l
      assign left_value = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_mid_r
      assign right_value = entry[i+1];
    end

    plc_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .idx         (IDX_W'(i)),
      .left_value  (left_value),
      .right_value (right_value),
      .entry_r     (entry[i]),
      .hit_r       (hit[i]),
      .sel_r       (sel[i])
    );
  end

  plc_reduce u_reduce (
    .hit       (hit),
    .sel       (sel),
    .any_hit   (any_hit),
    .first_pos (first_pos),
    .sel_value (sel_value)
  );

  // Result register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_len_r <= count_r;
      if (cmd_r == CMD_FIND) begin
        out_ok_r <= any_hit;
        out_fp_r <= first_pos;
        out_rd_r <= '0;
      end else begin
        out_ok_r <= ok_r;
        out_fp_r <= '0;
        out_rd_r <= ((cmd_r == CMD_READ) && ok_r) ? sel_value : '0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.ok             = out_ok_r;
  assign out_ch.read_value     = out_rd_r;
  assign out_ch.found_position = out_fp_r;
  assign out_ch.list_length    = out_len_r;

endmodule

>>> bench/positional_array_list_test.sv
// ----------------------------------------------------------------------------
// positional_array_list_test: self-checking bench for the positional array list
// Drives insert, delete, read and find commands under random source gaps and
// sink stalls. Each result beat, predicted by a shadow list or typed into a row, is
// checked field by field, across several capacity settings including the extremes.
// ----------------------------------------------------------------------------
module positional_array_list_test;
  import plc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int REPORT_LINES   = 30;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_NEG = 32'hFFFF_FFFF;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        found_position;
    logic [LEN_W-1:0]        list_length;
  } list_result_t;

  typedef struct {
    plc_cmd_t                cmd;
    logic [LEN_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    bit                      typed;
    list_result_t            want;
  } directed_row_t;

  typedef struct {
    logic [LEN_W-1:0] cap;
    bit               pick_cap;
    int               ins_pct;
    int               del_pct;
    int               items;
  } phase_t;

  logic clk = 1'b0;
  logic rst_n;

  plc_in_if  in_ch();
  plc_out_if out_ch();
  plc_cfg_if cfg_ch();

  positional_array_list u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // Shadow copy of the list, its length and the capacity register
  logic signed [VAL_W-1:0] shadow_list [DEPTH];
  int                      shadow_len = 0;
  int                      shadow_cap = CAP_RESET;

  list_result_t pending_results [$];
  list_result_t staged_result = '0;
  int           mismatch_count = 0;
  int           result_beats = 0;
  int           idle_cycles = 0;
  bit           steady = 1'b0;
  int           stall_left = 0;

  // Typed-in rows read straight off the behaviour; the rest use the shadow list
  directed_row_t directed_rows [24] = '{
    '{CMD_READ,   7'd0 + 7'd1, 32'sd0,   1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
    '{CMD_DELETE, 7'd1,   32'sd0,        1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
    '{CMD_FIND,   7'd0,   32'sd0,        1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
    '{CMD_INSERT, 7'd0,   32'sd5,        1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
    '{CMD_INSERT, 7'd2,   32'sd5,        1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
    '{CMD_INSERT, 7'd1,   VAL_MAX,       1'b1, '{1'b1, 32'sd0, 7'd0, 7'd1}},
    '{CMD_INSERT, 7'd1,   VAL_MIN,       1'b1, '{1'b1, 32'sd0, 7'd0, 7'd2}},
    '{CMD_INSERT, 7'd3,   VAL_NEG,       1'b1, '{1'b1, 32'sd0, 7'd0, 7'd3}},
    '{CMD_INSERT, 7'd2,   32'sd0,        1'b0, '0},
    '{CMD_READ,   7'd1,   32'sd0,        1'b1, '{1'b1, VAL_MIN, 7'd0, 7'd4}},
    '{CMD_READ,   7'd4,   32'sd0,        1'b0, '0},
    '{CMD_READ,   7'd5,   32'sd0,        1'b1, '{1'b0, 32'sd0, 7'd0, 7'd4}},
    '{CMD_READ,   7'd127, VAL_NEG,       1'b1, '{1'b0, 32'sd0, 7'd0, 7'd4}},
    '{CMD_FIND,   7'd0,   VAL_NEG,       1'b0, '0},
    '{CMD_FIND,   7'd127, VAL_MAX,       1'b0, '0},
    '{CMD_FIND,   7'd1,   32'sd12345,    1'b1, '{1'b0, 32'sd0, 7'd0, 7'd4}},
    '{CMD_INSERT, 7'd4,   32'sd0,        1'b0, '0},
    '{CMD_FIND,   7'd0,   32'sd0,        1'b0, '0},
    '{CMD_DELETE, 7'd0,   32'sd0,        1'b1, '{1'b0, 32'sd0, 7'd0, 7'd5}},
    '{CMD_DELETE, 7'd6,   32'sd0,        1'b1, '{1'b0, 32'sd0, 7'd0, 7'd5}},
    '{CMD_DELETE, 7'd5,   VAL_MIN,       1'b0, '0},
    '{CMD_DELETE, 7'd1,   32'sd0,        1'b0, '0},
    '{CMD_INSERT, 7'd127, 32'sd7,        1'b1, '{1'b0, 32'sd0, 7'd0, 7'd3}},
    '{CMD_READ,   7'd0,   32'sd0,        1'b1, '{1'b0, 32'sd0, 7'd0, 7'd3}}
  };

  // Capacity settings walked after the directed part
  phase_t phases [9] = '{
    '{7'd64,  1'b0, 60, 15, 130},
    '{7'd127, 1'b0, 60, 15, 130},
    '{7'd3,   1'b0, 20, 70, 180},
    '{7'd0,   1'b0, 30, 30, 100},
    '{7'd65,  1'b0, 55, 20, 130},
    '{7'd1,   1'b0, 40, 30, 110},
    '{7'd0,   1'b1, 45, 25, 130},
    '{7'd64,  1'b0, 40, 30, 130},
    '{7'd2,   1'b0, 35, 35, 110}
  };

  // Apply one command to the shadow list and return the result it gives
  function automatic list_result_t apply_command(plc_cmd_t cmd, logic [LEN_W-1:0] pos,
                                                 logic signed [VAL_W-1:0] val);
    list_result_t res;
    int           limit;
    int           p;
    int           j;
    res   = '0;
    p     = pos;
    limit = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    case (cmd)
      CMD_INSERT: begin
        if (shadow_len < limit && p >= 1 && p <= shadow_len + 1) begin
          for (j = shadow_len; j >= p; j--) shadow_list[j] = shadow_list[j-1];
          shadow_list[p-1] = val;
          shadow_len++;
          res.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (p >= 1 && p <= shadow_len) begin
          for (j = p - 1; j + 1 < shadow_len; j++) shadow_list[j] = shadow_list[j+1];
          shadow_len--;
          res.ok = 1'b1;
        end
      end
      CMD_READ: begin
        if (p >= 1 && p <= shadow_len) begin
          res.read_value = shadow_list[p-1];
          res.ok         = 1'b1;
        end
      end
      default: begin
        for (j = 0; j < shadow_len && !res.ok; j++) begin
          if (shadow_list[j] == val) begin
            res.found_position = LEN_W'(j + 1);
            res.ok             = 1'b1;
          end
        end
      end
    endcase
    res.list_length = LEN_W'(shadow_len);
    return res;
  endfunction

  // Mostly back-to-back, sometimes short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES)
      $display("mismatch at result beat %0d: %s got %0d expected %0d",
               result_beats, what, got, want);
  endtask

  // Present one command beat and hold it until it is taken
  task automatic send_command(plc_cmd_t cmd, logic [LEN_W-1:0] pos,
                              logic signed [VAL_W-1:0] val, bit typed, list_result_t want);
    int           gap;
    list_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predicted = apply_command(cmd, pos, val);
    staged_result       <= typed ? want : predicted;
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.position      <= pos;
    in_ch.item_value    <= val;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every result, then let the pipeline settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [LEN_W-1:0] cap);
    wait_drained();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.capacity_limit <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shadow_cap = cap;
  endtask

  // Random commands, mostly at live positions and often hitting stored values
  task automatic run_random(int n, int ins_pct, int del_pct);
    plc_cmd_t                cmd;
    logic [LEN_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    int                      roll;
    int                      hi;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) cmd = CMD_INSERT;
      else if (roll < ins_pct + del_pct) cmd = CMD_DELETE;
      else cmd = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_FIND;

      hi   = (cmd == CMD_INSERT) ? shadow_len + 1 : shadow_len;
      roll = $urandom_range(0, 99);
      if (roll < 75) pos = (hi == 0) ? LEN_W'(1) : LEN_W'($urandom_range(1, hi));
      else if (roll < 85) pos = ($urandom_range(0, 1) == 0) ? LEN_W'(0) : LEN_W'(hi + 1);
      else pos = LEN_W'($urandom_range(0, 127));

      roll = $urandom_range(0, 99);
      if (cmd == CMD_FIND && shadow_len > 0 && roll < 50) begin
        val = shadow_list[$urandom_range(0, shadow_len - 1)];
      end else if (roll < 70) begin
        val = $urandom_range(0, 7);
        val = val - 4;
      end else if (roll < 80) begin
        case ($urandom_range(0, 3))
          0:       val = VAL_MIN;
          1:       val = VAL_MAX;
          2:       val = VAL_NEG;
          default: val = '0;
        endcase
      end else begin
        val = $urandom;
      end
      send_command(cmd, pos, val, 1'b0, '0);
    end
  endtask

  // Result sink: ready with random stalls, none while steady
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 99) < 20) begin
      stall_left = pick_gap();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check result beats first, then queue the expectation of a taken command
  always @(posedge clk) begin
    list_result_t want;
    bit           moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        result_beats++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, list_length", out_ch.list_length, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.ok !== want.ok)
            report_mismatch("ok", out_ch.ok, want.ok);
          if (out_ch.read_value !== want.read_value)
            report_mismatch("read_value", out_ch.read_value, want.read_value);
          if (out_ch.found_position !== want.found_position)
            report_mismatch("found_position", out_ch.found_position, want.found_position);
          if (out_ch.list_length !== want.list_length)
            report_mismatch("list_length", out_ch.list_length, want.list_length);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        pending_results.push_back(staged_result);
      end
      if (cfg_ch.valid && cfg_ch.ready) moved = 1'b1;

      // Watchdog: end the run if nothing moves for too long
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, a random run, then one random phase per capacity
  initial begin
    logic [LEN_W-1:0] cap;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.command         <= CMD_INSERT;
    in_ch.position        <= '0;
    in_ch.item_value      <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.capacity_limit <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].want);
    run_random(220, 50, 20);

    foreach (phases[p]) begin
      cap = phases[p].pick_cap ? LEN_W'($urandom_range(4, 63)) : phases[p].cap;
      write_capacity(cap);
      steady = (p % 3 == 1);
      run_random(phases[p].items, phases[p].ins_pct, phases[p].del_pct);
    end

    wait_drained();
    if (pending_results.size() != 0)
      report_mismatch("results still outstanding", pending_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/plc_pkg.sv
design/plc_ifs.sv
design/plc_cell.sv
design/plc_reduce.sv
design/positional_array_list.sv
bench/positional_array_list_test.sv
